/* rtl/core/stree_pkg.sv */
// Shared types and constants for the segment tree range min/max/sum block.
// Used by the tree engine and the top level.
package stree_pkg;

	localparam int N_ELEMENTS_DEF = 256;
	localparam int VALUE_BITS_DEF = 32;
	localparam int IDX_W          = 8;
	localparam int OUT_W          = 32;
	localparam int SUM_W          = 40;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LEAF_RD,
		S_LEAF_WAIT,
		S_LEAF_WR,
		S_UP_RDL,
		S_UP_RDR,
		S_UP_WAIT,
		S_UP_WR,
		S_Q_STEP,
		S_Q_RD,
		S_Q_WAIT,
		S_Q_ACC,
		S_DONE
	} fsm_t;

endpackage

/* rtl/core/segment_tree_range_min_max_sum_top.sv */
// Top level of the segment tree range min/max/sum block.
// Depends on stree_pkg and stree_engine.
//
// Usage: one input channel (in_valid/in_stall) carries a command with its
// element index, value and range; one output channel (out_valid/out_stall)
// returns exactly one result per command, in order.
// Set and add rewrite one leaf and rebuild its ancestors through the single
// node-memory port, which does one access per cycle. A query visits at most
// two nodes per level. Invalid commands skip the tree and go straight to the
// result register.
// One command is worked at a time; the next is taken once the result sits in
// the output register, even while the receiver still stalls it.
// After reset the node memory is swept to identity values, one node per
// cycle over all 2*N-1 nodes; in_stall stays high meanwhile.
// A stalled result holds its payload until transferred.
module segment_tree_range_min_max_sum_top #(
	parameter int N_ELEMENTS = stree_pkg::N_ELEMENTS_DEF,
	parameter int VALUE_BITS = stree_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          command,
	input  logic [stree_pkg::IDX_W-1:0]         element_index,
	input  logic signed [31:0]                  value,
	input  logic [stree_pkg::IDX_W-1:0]         range_low,
	input  logic [stree_pkg::IDX_W-1:0]         range_high,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [stree_pkg::OUT_W-1:0]  min_value,
	output logic signed [stree_pkg::OUT_W-1:0]  max_value,
	output logic signed [stree_pkg::SUM_W-1:0]  sum_value,
	output logic [1:0]                          status
);

	logic signed [VALUE_BITS-1:0] mn, mx;

	stree_engine #(.N_ELEMENTS(N_ELEMENTS), .VALUE_BITS(VALUE_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .element_index(element_index), .value(value),
		.range_low(range_low), .range_high(range_high),
		.res_valid(out_valid), .res_take(!out_stall),
		.res_min(mn), .res_max(mx), .res_sum(sum_value), .res_status(status)
	);

	// extend element width to the port width
	assign min_value = stree_pkg::OUT_W'(mn);
	assign max_value = stree_pkg::OUT_W'(mx);

endmodule

/* rtl/core/stree_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module stree_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read one entry per cycle, writing it when we is set; the read returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/core/stree_engine.sv */
// Tree sequencer: clears the node memory, walks updates up the tree and
// queries up the tree by narrowing the bounds. Depends on stree_pkg and stree_ram.
module stree_engine #(
	parameter int N_ELEMENTS = stree_pkg::N_ELEMENTS_DEF,
	parameter int VALUE_BITS = stree_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [stree_pkg::IDX_W-1:0]   element_index,
	input  logic signed [31:0]            value,
	input  logic [stree_pkg::IDX_W-1:0]   range_low,
	input  logic [stree_pkg::IDX_W-1:0]   range_high,
	output logic                          res_valid,
	input  logic                          res_take,
	output logic signed [VALUE_BITS-1:0]  res_min,
	output logic signed [VALUE_BITS-1:0]  res_max,
	output logic signed [stree_pkg::SUM_W-1:0] res_sum,
	output logic [1:0]                    res_status
);

	localparam int NODES = 2 * N_ELEMENTS - 1;
	localparam int AW    = $clog2(2 * N_ELEMENTS);
	localparam int VB    = VALUE_BITS;
	localparam int SW    = stree_pkg::SUM_W;
	localparam int WORD  = 2 * VB + SW;
	localparam int EXT   = (VB > 32) ? VB + 1 : 33;
	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic [WORD-1:0] IDENT = {VMAX, VMIN, {SW{1'b0}}};
	localparam logic [AW:0] NEL = (AW+1)'(N_ELEMENTS);

	stree_pkg::fsm_t st_q, st_d;

	logic              we;
	logic [AW-1:0]     addr;
	logic [WORD-1:0]   wdata, rdata;
	logic [AW-1:0]     ptr_q;
	logic [AW:0]       l_q, r_q;
	logic              side_q;
	logic [1:0]        cmd_q;
	logic signed [VB-1:0]  mn_q, mx_q;
	logic signed [SW-1:0]  sm_q;
	logic [WORD-1:0]   left_q;
	logic [1:0]        stat_q;
	logic signed [31:0] val_q;
	logic              busy_done;

	stree_ram #(.WIDTH(WORD), .DEPTH(NODES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// split read word
	logic signed [VB-1:0] rd_mn, rd_mx, lf_mn, lf_mx;
	logic signed [SW-1:0] rd_sm, lf_sm;
	assign {rd_mn, rd_mx, rd_sm} = rdata;
	assign {lf_mn, lf_mx, lf_sm} = left_q;

	// saturate new leaf value
	logic signed [EXT-1:0] raw_ext, vmax_e, vmin_e;
	logic signed [VB-1:0]  leaf_v;
	logic                  leaf_sat;
	always_comb begin
		raw_ext = EXT'(val_q);
		if (cmd_q == stree_pkg::CMD_ADD) begin
			raw_ext = EXT'(val_q) + EXT'($signed(rd_sm[VB-1:0]));
		end
		vmax_e = EXT'(VMAX);
		vmin_e = EXT'(VMIN);
		leaf_sat = 1'b0;
		leaf_v = raw_ext[VB-1:0];
		if (raw_ext > vmax_e) begin
			leaf_v = VMAX;
			leaf_sat = 1'b1;
		end else if (raw_ext < vmin_e) begin
			leaf_v = VMIN;
			leaf_sat = 1'b1;
		end
	end

	// query bounds
	logic [AW:0] lo_e, hi_e;
	assign lo_e = (AW+1)'(range_low);
	assign hi_e = ((AW+1)'(range_high) >= NEL) ? NEL - 1'b1 : (AW+1)'(range_high);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			stree_pkg::S_CLEAR:
				if (ptr_q == AW'(NODES - 1)) st_d = stree_pkg::S_IDLE;
			stree_pkg::S_IDLE:
				if (in_valid) begin
					if ((command == stree_pkg::CMD_SET || command == stree_pkg::CMD_ADD)
					    && (AW+1)'(element_index) < NEL) begin
						st_d = stree_pkg::S_LEAF_RD;
					end else if (command == stree_pkg::CMD_QUERY && range_low <= range_high
					    && lo_e < NEL) begin
						st_d = stree_pkg::S_Q_STEP;
					end else begin
						st_d = stree_pkg::S_DONE;
					end
				end
			stree_pkg::S_LEAF_RD:   st_d = stree_pkg::S_LEAF_WAIT;
			stree_pkg::S_LEAF_WAIT: st_d = stree_pkg::S_LEAF_WR;
			stree_pkg::S_LEAF_WR:
				st_d = (ptr_q == '0) ? stree_pkg::S_DONE : stree_pkg::S_UP_RDL;
			stree_pkg::S_UP_RDL:    st_d = stree_pkg::S_UP_RDR;
			stree_pkg::S_UP_RDR:    st_d = stree_pkg::S_UP_WAIT;
			stree_pkg::S_UP_WAIT:   st_d = stree_pkg::S_UP_WR;
			stree_pkg::S_UP_WR:
				st_d = (ptr_q == '0) ? stree_pkg::S_DONE : stree_pkg::S_UP_RDL;
			stree_pkg::S_Q_STEP:
				if (l_q >= r_q) st_d = stree_pkg::S_DONE;
				else if (l_q[0] || r_q[0]) st_d = stree_pkg::S_Q_RD;
			stree_pkg::S_Q_RD:      st_d = stree_pkg::S_Q_WAIT;
			stree_pkg::S_Q_WAIT:    st_d = stree_pkg::S_Q_ACC;
			stree_pkg::S_Q_ACC:     st_d = stree_pkg::S_Q_STEP;
			stree_pkg::S_DONE:
				if (!res_valid || res_take) st_d = stree_pkg::S_IDLE;
			default:                st_d = stree_pkg::S_IDLE;
		endcase
	end

	// memory port control; hold the read address through the wait cycle
	always_comb begin
		we = 1'b0;
		addr = ptr_q;
		wdata = IDENT;
		case (st_q)
			stree_pkg::S_CLEAR: we = 1'b1;
			stree_pkg::S_LEAF_WR: begin
				we = 1'b1;
				wdata = {leaf_v, leaf_v, SW'(leaf_v)};
			end
			stree_pkg::S_UP_RDL: addr = AW'(2 * ptr_q + 1);
			stree_pkg::S_UP_RDR, stree_pkg::S_UP_WAIT: addr = AW'(2 * ptr_q + 2);
			stree_pkg::S_UP_WR: begin
				we = 1'b1;
				wdata = {(lf_mn < rd_mn) ? lf_mn : rd_mn,
				         (lf_mx > rd_mx) ? lf_mx : rd_mx,
				         SW'(lf_sm + rd_sm)};
			end
			stree_pkg::S_Q_RD, stree_pkg::S_Q_WAIT:
				addr = side_q ? AW'(r_q - 2'd2) : AW'(l_q - 1'b1);
			default: ;
		endcase
	end

	assign in_stall = (st_q != stree_pkg::S_IDLE);
	assign busy_done = (st_q == stree_pkg::S_DONE) && (!res_valid || res_take);

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= stree_pkg::S_CLEAR;
			ptr_q <= '0;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			res_valid <= busy_done || (res_valid && !res_take);
			case (st_q)
				stree_pkg::S_CLEAR: ptr_q <= ptr_q + 1'b1;
				stree_pkg::S_IDLE:
					ptr_q <= AW'(N_ELEMENTS - 1) + AW'(element_index);
				stree_pkg::S_LEAF_WR, stree_pkg::S_UP_WR:
					if (ptr_q != '0) ptr_q <= AW'((ptr_q - 1'b1) >> 1);
				default: ;
			endcase
		end
	end

	// payload and accumulators
	always_ff @(posedge clk) begin
		case (st_q)
			stree_pkg::S_IDLE: begin
				cmd_q <= command;
				val_q <= value;
				mn_q <= VMAX;
				mx_q <= VMIN;
				sm_q <= '0;
				stat_q <= (command == stree_pkg::CMD_QUERY && range_low > range_high) ?
				          stree_pkg::ST_EMPTY : stree_pkg::ST_OK;
				l_q <= lo_e + NEL;
				r_q <= hi_e + NEL + 1'b1;
			end
			stree_pkg::S_LEAF_WR: begin
				mn_q <= leaf_v;
				mx_q <= leaf_v;
				sm_q <= SW'(leaf_v);
				if (leaf_sat) stat_q <= stree_pkg::ST_SAT;
			end
			stree_pkg::S_UP_RDR: left_q <= rdata;
			stree_pkg::S_Q_STEP:
				if (l_q[0]) side_q <= 1'b0;
				else if (r_q[0]) side_q <= 1'b1;
				else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			stree_pkg::S_Q_ACC: begin
				if (rd_mn < mn_q) mn_q <= rd_mn;
				if (rd_mx > mx_q) mx_q <= rd_mx;
				sm_q <= sm_q + rd_sm;
				if (side_q) r_q <= r_q - 1'b1;
				else l_q <= l_q + 1'b1;
			end
			default: ;
		endcase
		if (busy_done) begin
			res_min <= mn_q;
			res_max <= mx_q;
			res_sum <= sm_q;
			res_status <= stat_q;
		end
	end

endmodule
